### hw/rtl/bgc_pkg.sv
// shared constants and types for the bit gather compactor
`timescale 1ns / 1ps

package bgc_pkg;

    // port widths fixed by the stream format
    localparam int PORT_WORD_W   = 64;
    localparam int PORT_CNT_W    = 7;

    // default gather word width
    localparam int WORD_BITS_DEF = 64;

    // result queue geometry
    localparam int Q_DEPTH       = 4;
    localparam int Q_PTR_W       = $clog2(Q_DEPTH);
    localparam int Q_CNT_W       = $clog2(Q_DEPTH + 1);

    // one result item as it leaves the block
    typedef struct packed {
        logic [PORT_WORD_W-1:0] word;
        logic [PORT_CNT_W-1:0]  count;
        logic                   last;
    } t_result;

endpackage

### hw/rtl/bgc_compress.sv
// parallel bit extract of one data word under its mask, with popcount
`timescale 1ns / 1ps

module bgc_compress #(
    parameter int WORD_BITS = bgc_pkg::WORD_BITS_DEF
) (
    input  logic [WORD_BITS-1:0]             i_mask,
    input  logic [WORD_BITS-1:0]             i_data,
    output logic [WORD_BITS-1:0]             o_bits,
    output logic [$clog2(WORD_BITS+1)-1:0]   o_count
);

    localparam int KW = $clog2(WORD_BITS + 1);
    localparam int LG = $clog2(WORD_BITS);

    logic [KW-1:0] ks [0:LG][0:WORD_BITS-1];
    logic [WORD_BITS-1:0] bits;

    // inclusive prefix count of mask bits, log-depth tree
    always_comb begin
        for (int i = 0; i < WORD_BITS; i++) begin
            ks[0][i] = KW'(i_mask[i]);
        end
        for (int s = 0; s < LG; s++) begin
            for (int i = 0; i < WORD_BITS; i++) begin
                if (i >= (1 << s)) begin
                    ks[s+1][i] = ks[s][i] + ks[s][i - (1 << s)];
                end else begin
                    ks[s+1][i] = ks[s][i];
                end
            end
        end
    end

    // output bit j takes the selected data bit whose rank is j
    always_comb begin
        for (int j = 0; j < WORD_BITS; j++) begin
            bits[j] = 1'b0;
            for (int i = 0; i < WORD_BITS; i++) begin
                if (i_mask[i] && (ks[LG][i] == KW'(j + 1))) begin
                    bits[j] = bits[j] | i_data[i];
                end
            end
        end
    end

    assign o_bits  = bits;
    assign o_count = ks[LG][WORD_BITS-1];

endmodule

### hw/rtl/bgc_merge.sv
// running accumulator that packs gathered bits into full and flush words
`timescale 1ns / 1ps

module bgc_merge #(
    parameter int WORD_BITS = bgc_pkg::WORD_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_fire,
    input  logic [WORD_BITS-1:0]            i_bits,
    input  logic [$clog2(WORD_BITS+1)-1:0]  i_count,
    input  logic                            i_last,
    output logic                            o_push0,
    output logic                            o_push1,
    output bgc_pkg::t_result                o_res0,
    output bgc_pkg::t_result                o_res1
);

    localparam int FW = $clog2(WORD_BITS);
    localparam int TW = $clog2(WORD_BITS) + 1;
    localparam int W2 = 2 * WORD_BITS;

    logic [WORD_BITS-2:0] r_acc, n_acc;
    logic [FW-1:0]        r_fill, n_fill;

    logic [W2-1:0]        combined;
    logic [TW-1:0]        total;
    logic                 have_full;
    logic [FW-1:0]        rem_fill;
    logic [WORD_BITS-1:0] full_word;
    logic [WORD_BITS-1:0] rem_bits;
    bgc_pkg::t_result     full_res;
    bgc_pkg::t_result     flush_res;

    // place new bits above the pending ones
    always_comb begin
        combined  = W2'(r_acc) | (W2'(i_bits) << r_fill);
        total     = TW'(r_fill) + TW'(i_count);
        have_full = (total >= TW'(WORD_BITS));
        full_word = combined[WORD_BITS-1:0];
        if (have_full) begin
            rem_fill = FW'(total - TW'(WORD_BITS));
            rem_bits = combined[W2-1:WORD_BITS];
        end else begin
            rem_fill = FW'(total);
            rem_bits = combined[WORD_BITS-1:0];
        end
    end

    // result items for this input item
    always_comb begin
        full_res.word  = bgc_pkg::PORT_WORD_W'(full_word);
        full_res.count = bgc_pkg::PORT_CNT_W'(WORD_BITS);
        full_res.last  = i_last && (rem_fill == '0);

        flush_res.word  = bgc_pkg::PORT_WORD_W'(rem_bits);
        flush_res.count = bgc_pkg::PORT_CNT_W'(rem_fill);
        flush_res.last  = 1'b1;

        o_push0 = i_fire && (have_full || i_last);
        o_push1 = i_fire && have_full && i_last && (rem_fill != '0);
        o_res0  = have_full ? full_res : flush_res;
        o_res1  = flush_res;
    end

    // accumulator next state, cleared at the end of a vector
    always_comb begin
        n_acc  = r_acc;
        n_fill = r_fill;
        if (i_fire) begin
            if (i_last) begin
                n_acc  = '0;
                n_fill = '0;
            end else begin
                n_acc  = rem_bits[WORD_BITS-2:0];
                n_fill = rem_fill;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc  <= '0;
            r_fill <= '0;
        end else begin
            r_acc  <= n_acc;
            r_fill <= n_fill;
        end
    end

endmodule

### hw/rtl/bgc_queue.sv
// small result queue taking up to two items per cycle, giving one when popped
`timescale 1ns / 1ps

module bgc_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push0,
    input  logic             i_push1,
    input  bgc_pkg::t_result i_res0,
    input  bgc_pkg::t_result i_res1,
    input  logic             i_pop,
    output logic             o_valid,
    output bgc_pkg::t_result o_head,
    output logic             o_room
);

    bgc_pkg::t_result             r_mem [0:bgc_pkg::Q_DEPTH-1];
    logic [bgc_pkg::Q_PTR_W-1:0]  r_wp, n_wp;
    logic [bgc_pkg::Q_PTR_W-1:0]  r_rp, n_rp;
    logic [bgc_pkg::Q_CNT_W-1:0]  r_cnt, n_cnt;
    logic                         pop_ok;

    assign pop_ok  = i_pop && (r_cnt != '0);
    assign o_valid = (r_cnt != '0);
    assign o_head  = r_mem[r_rp];
    // room for the worst case of two items
    assign o_room  = (r_cnt <= bgc_pkg::Q_CNT_W'(bgc_pkg::Q_DEPTH - 2));

    // pointer and occupancy update
    always_comb begin
        n_wp  = r_wp + bgc_pkg::Q_PTR_W'(i_push0) + bgc_pkg::Q_PTR_W'(i_push1);
        n_rp  = r_rp + bgc_pkg::Q_PTR_W'(pop_ok);
        n_cnt = r_cnt + bgc_pkg::Q_CNT_W'(i_push0) + bgc_pkg::Q_CNT_W'(i_push1)
              - bgc_pkg::Q_CNT_W'(pop_ok);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push0) begin
            r_mem[r_wp] <= i_res0;
        end
        if (i_push1) begin
            r_mem[r_wp + bgc_pkg::Q_PTR_W'(1)] <= i_res1;
        end
    end

endmodule

### hw/rtl/bitvector_gather_compact_unit.sv
// top level of the streaming bit gather compactor
// an input item goes through the input register and then the result queue to the output
// throughput: one input item per cycle without i_stall while each gives at most one result;
// an item that completes a word and flushes a tail gives two, set by the single output port
// reset: synchronous active-low reset empties the input register, accumulator and queue
`timescale 1ns / 1ps

module bitvector_gather_compact_unit #(
    parameter int WORD_BITS = bgc_pkg::WORD_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic [bgc_pkg::PORT_WORD_W-1:0]    i_mask_word,
    input  logic [bgc_pkg::PORT_WORD_W-1:0]    i_data_word,
    input  logic                               i_last_in,
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic [bgc_pkg::PORT_WORD_W-1:0]    o_packed_word,
    output logic [bgc_pkg::PORT_CNT_W-1:0]     o_bit_count,
    output logic                               o_last_out
);

    localparam int KW = $clog2(WORD_BITS + 1);

    logic                 r_in_valid;
    logic [WORD_BITS-1:0] r_mask;
    logic [WORD_BITS-1:0] r_data;
    logic                 r_last;

    logic                 q_room;
    logic                 fire;
    logic [WORD_BITS-1:0] ext_bits;
    logic [KW-1:0]        ext_count;
    logic                 push0, push1;
    bgc_pkg::t_result     res0, res1, head;

    // held item moves on when the queue can take two results
    assign fire    = r_in_valid && q_room;
    assign o_stall = r_in_valid && !q_room;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_mask <= i_mask_word[WORD_BITS-1:0];
            r_data <= i_data_word[WORD_BITS-1:0];
            r_last <= i_last_in;
        end
    end

    // gather selected bits
    bgc_compress #(
        .WORD_BITS (WORD_BITS)
    ) u_compress (
        .i_mask  (r_mask),
        .i_data  (r_data),
        .o_bits  (ext_bits),
        .o_count (ext_count)
    );

    // pack into words
    bgc_merge #(
        .WORD_BITS (WORD_BITS)
    ) u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_bits  (ext_bits),
        .i_count (ext_count),
        .i_last  (r_last),
        .o_push0 (push0),
        .o_push1 (push1),
        .o_res0  (res0),
        .o_res1  (res1)
    );

    // result queue drives the output channel
    bgc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push0 (push0),
        .i_push1 (push1),
        .i_res0  (res0),
        .i_res1  (res1),
        .i_pop   (!i_stall),
        .o_valid (o_valid),
        .o_head  (head),
        .o_room  (q_room)
    );

    assign o_packed_word = head.word;
    assign o_bit_count   = head.count;
    assign o_last_out    = head.last;

endmodule

### bench/bitvector_gather_compact_unit_check.sv
// checker for the bit gather compactor: predicts packed words and compares them
`timescale 1ns / 1ps

module bitvector_gather_compact_unit_check #(
    parameter int WORD_BITS = bgc_pkg::WORD_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    input  logic                             i_in_stall,
    input  logic [bgc_pkg::PORT_WORD_W-1:0]  i_mask_word,
    input  logic [bgc_pkg::PORT_WORD_W-1:0]  i_data_word,
    input  logic                             i_last_in,
    input  logic                             i_out_valid,
    input  logic                             i_out_stall,
    input  logic [bgc_pkg::PORT_WORD_W-1:0]  i_packed_word,
    input  logic [bgc_pkg::PORT_CNT_W-1:0]   i_bit_count,
    input  logic                             i_last_out,
    output int                               o_error_count,
    output int                               o_backlog
);

    localparam logic [bgc_pkg::PORT_WORD_W-1:0] WORD_MASK =
        {bgc_pkg::PORT_WORD_W{1'b1}} >> (64 - WORD_BITS);

    // running gather state of the current vector
    logic [62:0]         pend_bits;
    logic [5:0]          pend_fill;
    bgc_pkg::t_result    packed_expected[$];

    // gather one input item and queue the packed words it completes
    task automatic gather_item(input logic [bgc_pkg::PORT_WORD_W-1:0] sel_raw,
                               input logic [bgc_pkg::PORT_WORD_W-1:0] dat_raw,
                               input logic last);
        logic [bgc_pkg::PORT_WORD_W-1:0] sel;
        logic [bgc_pkg::PORT_WORD_W-1:0] dat;
        logic [bgc_pkg::PORT_WORD_W-1:0] acc;
        logic [bgc_pkg::PORT_WORD_W-1:0] full;
        bit                              have_full;
        int                              fill;
        int                              i;
        bgc_pkg::t_result                res;
        sel       = sel_raw & WORD_MASK;
        dat       = dat_raw & WORD_MASK;
        acc       = {1'b0, pend_bits};
        fill      = pend_fill;
        full      = '0;
        have_full = 1'b0;
        for (i = 0; i < WORD_BITS; i++) begin
            if (sel[i]) begin
                acc[fill] = dat[i];
                fill++;
                if (fill >= WORD_BITS) begin
                    full      = acc;
                    have_full = 1'b1;
                    acc       = '0;
                    fill      = 0;
                end
            end
        end
        // completed word, marked last only when nothing is left behind it
        if (have_full) begin
            res.word  = full & WORD_MASK;
            res.count = bgc_pkg::PORT_CNT_W'(WORD_BITS);
            res.last  = last && (fill == 0);
            packed_expected.push_back(res);
        end
        // tail flush, or an empty last word
        if (last) begin
            if (fill != 0 || !have_full) begin
                res.word  = acc & WORD_MASK;
                res.count = bgc_pkg::PORT_CNT_W'(fill);
                res.last  = 1'b1;
                packed_expected.push_back(res);
            end
            acc  = '0;
            fill = 0;
        end
        pend_bits = acc[62:0];
        pend_fill = fill[5:0];
    endtask

    // watch both channels
    always @(posedge i_clk) begin
        bgc_pkg::t_result want;
        int               errs;
        errs = 0;
        if (!i_rst_n) begin
            pend_bits = '0;
            pend_fill = '0;
            packed_expected.delete();
            o_error_count <= 0;
            o_backlog     <= 0;
        end else begin
            if (i_in_valid && !i_in_stall) begin
                gather_item(i_mask_word, i_data_word, i_last_in);
            end
            if (i_out_valid && !i_out_stall) begin
                if (packed_expected.size() == 0) begin
                    $display("%0t: unexpected packed item: expected none, %s %h %0d %0b",
                             $time, "actual word count last", i_packed_word,
                             i_bit_count, i_last_out);
                    errs++;
                end else begin
                    want = packed_expected.pop_front();
                    if (i_packed_word !== want.word) begin
                        $display("%0t: packed_word mismatch: expected %h actual %h",
                                 $time, want.word, i_packed_word);
                        errs++;
                    end
                    if (i_bit_count !== want.count) begin
                        $display("%0t: bit_count mismatch: expected %0d actual %0d",
                                 $time, want.count, i_bit_count);
                        errs++;
                    end
                    if (i_last_out !== want.last) begin
                        $display("%0t: last_out mismatch: expected %0b actual %0b",
                                 $time, want.last, i_last_out);
                        errs++;
                    end
                end
            end
            o_error_count <= o_error_count + errs;
            o_backlog     <= packed_expected.size();
        end
    end

endmodule

### bench/bitvector_gather_compact_unit_test.sv
// testbench top for the bit gather compactor: stimulus, flow control and verdict
`timescale 1ns / 1ps

module bitvector_gather_compact_unit_test;

    localparam int RANDOM_ITEMS = 1200;
    localparam int CYCLE_LIMIT  = 400000;
    localparam logic [63:0] ONES = {64{1'b1}};

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            i_valid = 1'b0;
    logic                            o_stall;
    logic [bgc_pkg::PORT_WORD_W-1:0] i_mask_word = '0;
    logic [bgc_pkg::PORT_WORD_W-1:0] i_data_word = '0;
    logic                            i_last_in = 1'b0;
    logic                            o_valid;
    logic                            i_stall = 1'b0;
    logic [bgc_pkg::PORT_WORD_W-1:0] o_packed_word;
    logic [bgc_pkg::PORT_CNT_W-1:0]  o_bit_count;
    logic                            o_last_out;

    int error_count;
    int backlog;
    int cycle_count = 0;
    int items_sent = 0;
    int tx_idle_pct = 35;
    int rx_idle_pct = 62;

    bitvector_gather_compact_unit u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_mask_word   (i_mask_word),
        .i_data_word   (i_data_word),
        .i_last_in     (i_last_in),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_packed_word (o_packed_word),
        .o_bit_count   (o_bit_count),
        .o_last_out    (o_last_out)
    );

    bitvector_gather_compact_unit_check u_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_valid),
        .i_in_stall    (o_stall),
        .i_mask_word   (i_mask_word),
        .i_data_word   (i_data_word),
        .i_last_in     (i_last_in),
        .i_out_valid   (o_valid),
        .i_out_stall   (i_stall),
        .i_packed_word (o_packed_word),
        .i_bit_count   (o_bit_count),
        .i_last_out    (o_last_out),
        .o_error_count (error_count),
        .o_backlog     (backlog)
    );

    always #5 i_clk = ~i_clk;

    // receiver back-pressure
    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(0, 99) < rx_idle_pct);
    end

    // run watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("bitvector_gather_compact_unit_test: done, errors");
            $finish;
        end
    end

    function automatic logic [63:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    // mask shapes from empty to full
    function automatic logic [63:0] rand_mask();
        case ($urandom_range(0, 6))
            0: return '0;
            1: return ONES;
            2: return rand_word() & rand_word() & rand_word();
            3: return rand_word() | rand_word();
            4: return 64'd1 << $urandom_range(0, 63);
            5: return ONES >> $urandom_range(0, 63);
            default: return rand_word();
        endcase
    endfunction

    // offer one item with random sender gaps, wait until it is taken
    task automatic send_item(input logic [63:0] mask, input logic [63:0] data,
                             input logic last);
        // idling profile follows progress through the run
        if (items_sent < RANDOM_ITEMS / 3) begin
            tx_idle_pct = 35;
            rx_idle_pct = 62;
        end else if (items_sent < 2 * RANDOM_ITEMS / 3) begin
            tx_idle_pct = 62;
            rx_idle_pct = 35;
        end else begin
            tx_idle_pct = 0;
            rx_idle_pct = 0;
        end
        if ($urandom_range(0, 99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(0, 99) < tx_idle_pct) @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_mask_word <= mask;
        i_data_word <= data;
        i_last_in   <= last;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        items_sent++;
    endtask

    initial begin
        int len;
        int w;
        bit noisy;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty vector
        send_item('0, ONES, 1'b1);
        // one full word that is also the last
        send_item(ONES, ONES, 1'b1);
        // full word first, then a last word with nothing pending
        send_item(ONES, '0, 1'b0);
        send_item('0, rand_word(), 1'b1);
        // full word and tail flush from the same item
        send_item(64'h3FF, rand_word(), 1'b0);
        send_item(ONES, 64'hA5A5_5A5A_F00F_0FF0, 1'b1);
        // two half masks filling exactly one word
        send_item(64'hAAAA_AAAA_AAAA_AAAA, ONES, 1'b0);
        send_item(64'h5555_5555_5555_5555, '0, 1'b1);
        // top bit alone
        send_item(64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000, 1'b1);
        // single bits trickling in
        send_item(64'd1, '0, 1'b0);
        send_item(64'd1, 64'd1, 1'b0);
        send_item(64'd1, '0, 1'b0);
        send_item(64'h8000_0000_0000_0000, ONES, 1'b1);
        // accumulator at its fullest, then completed by one bit
        send_item(ONES >> 1, ONES, 1'b0);
        send_item(64'd1, 64'd1, 1'b0);
        send_item('0, '0, 1'b1);
        // accumulator at its fullest, then full word plus 63-bit tail
        send_item(ONES >> 1, ONES, 1'b0);
        send_item(ONES, 64'h0123_4567_89AB_CDEF, 1'b1);
        // all-zero data through a full mask
        send_item(ONES, '0, 1'b1);
        send_item(rand_word(), rand_word(), 1'b1);

        // random vectors, mostly well formed with occasional stray last flags
        while (items_sent < RANDOM_ITEMS) begin
            noisy = ($urandom_range(0, 99) < 15);
            len   = $urandom_range(1, 8);
            for (w = 0; w < len; w++) begin
                if (noisy)
                    send_item(rand_mask(), rand_word(), ($urandom_range(0, 3) == 0));
                else
                    send_item(rand_mask(), rand_word(), (w == len - 1));
            end
        end
        i_valid <= 1'b0;
        i_last_in <= 1'b1;

        // drain outstanding packed words, then watch for strays
        while (backlog != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (error_count == 0) begin
            $display("bitvector_gather_compact_unit_test: done, clean");
        end else begin
            $display("bitvector_gather_compact_unit_test: done, errors");
        end
        $finish;
    end

endmodule
